>>> hw/rtl/mouse_packet_cursor_tracker_unit_defines.svh
// Assertion macros for the mouse packet cursor tracker.
`ifndef MOUSE_PACKET_CURSOR_TRACKER_UNIT_DEFINES_SVH
`define MOUSE_PACKET_CURSOR_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define MPCT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpct check failed: label");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define MPCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpct check failed: label");
`else
`define MPCT_ASSERT_IMPL(label, ante, cons)
`define MPCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
`default_nettype none

package mpct_pkg;

    // Default coordinate width of the cursor position
    localparam int COORD_BITS_DEF = 12;

    // Width of the screen size registers
    localparam int SIZE_BITS = 13;

    // Reset values of the cursor and screen size
    localparam int RESET_X      = 5;
    localparam int RESET_Y      = 2;
    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 768;

    // Configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Status byte bit positions
    localparam int BIT_LEFT   = 0;
    localparam int BIT_RIGHT  = 1;
    localparam int BIT_MIDDLE = 2;
    localparam int BIT_XOVF   = 6;
    localparam int BIT_YOVF   = 7;

    // Byte position within a three-byte packet
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_XMOVE  = 2'd1,
        PH_YMOVE  = 2'd2
    } byte_phase_t;

    // One assembled packet
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] x_move;
        logic [7:0] y_move;
    } packet_t;

endpackage

`default_nettype wire

>>> hw/rtl/mpct_pkt_asm.sv
// Byte counter that gathers mouse bytes into three-byte packets.
`default_nettype none

module mpct_pkt_asm
    import mpct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] data_byte,
    output logic            pkt_valid,
    input  wire logic       pkt_ready,
    output packet_t         pkt
);

    byte_phase_t phase_reg;
    byte_phase_t phase_next;
    logic        byte_take;
    logic        status_we;
    logic        xmove_we;
    logic        pkt_load;
    logic [7:0]  status_reg;
    logic [7:0]  x_move_reg;
    packet_t     pkt_reg;
    logic        pkt_valid_reg;
    logic        pkt_valid_next;

    // Stall the byte stream only while a finished packet cannot move on
    assign byte_ready = !pkt_valid_reg || pkt_ready;
    assign byte_take  = byte_valid && byte_ready;

    // Advance the byte position on every accepted item
    always_comb
    begin
        phase_next = phase_reg;
        if (byte_take)
        begin
            case (phase_reg)
                PH_XMOVE: phase_next = PH_YMOVE;
                PH_YMOVE: phase_next = PH_STATUS;
                default:  phase_next = PH_XMOVE;
            endcase
        end
    end

    // Decode which latch the accepted byte goes to
    always_comb
    begin
        status_we = 1'b0;
        xmove_we  = 1'b0;
        pkt_load  = 1'b0;
        case (phase_reg)
            PH_XMOVE: xmove_we  = byte_take;
            PH_YMOVE: pkt_load  = byte_take;
            default:  status_we = byte_take;
        endcase
    end

    assign pkt_valid_next = pkt_load || (pkt_valid_reg && !pkt_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_STATUS;
            pkt_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pkt_valid_reg <= pkt_valid_next;
        end
    end

    // Hold the status and X bytes, then load the complete packet
    always_ff @(posedge clk)
    begin
        if (status_we)
        begin
            status_reg <= data_byte;
        end
        if (xmove_we)
        begin
            x_move_reg <= data_byte;
        end
        if (pkt_load)
        begin
            pkt_reg.status <= status_reg;
            pkt_reg.x_move <= x_move_reg;
            pkt_reg.y_move <= data_byte;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt       = pkt_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mpct_cursor.sv
// Cursor position update, clamp and result register.
`default_nettype none

module mpct_cursor
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int OUT_W      = ((2 * COORD_BITS + 5 + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [SIZE_BITS-1:0] screen_width,
    input  wire logic [SIZE_BITS-1:0] screen_height,
    input  wire logic                 pkt_valid,
    output logic                      pkt_ready,
    input  wire packet_t              pkt,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_W-1:0]          out_data
);

    // Signed sum width: coordinate plus sign plus one carry bit
    localparam int CW      = COORD_BITS + 2;
    localparam int SW      = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam int PAY_W   = 2 * COORD_BITS + 5;

    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_next;
    logic signed [CW-1:0]  sum_x;
    logic signed [CW-1:0]  sum_y;
    logic                  take;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic [PAY_W-1:0]      payload;

    // Largest legal coordinate for a screen size
    function automatic logic [COORD_BITS-1:0] top_coord(input logic [SIZE_BITS-1:0] size);
        logic [SW-1:0] size_ext;
        logic [SW-1:0] limit;
        logic [SW-1:0] dec;
        size_ext = SW'(size);
        limit    = SW'(1) << COORD_BITS;
        dec      = size_ext - SW'(1);
        if (size == '0)
        begin
            top_coord = '0;
        end
        else if (size_ext > limit)
        begin
            top_coord = '1;
        end
        else
        begin
            top_coord = dec[COORD_BITS-1:0];
        end
    endfunction

    // Clamp a signed position into 0 .. top
    function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [CW-1:0] p,
                                                         input logic [COORD_BITS-1:0] top);
        if (p[CW-1])
        begin
            clamp_axis = '0;
        end
        else if (p[CW-2:0] > {1'b0, top})
        begin
            clamp_axis = top;
        end
        else
        begin
            clamp_axis = p[COORD_BITS-1:0];
        end
    endfunction

    // Take a packet when the result register is free or being drained
    assign pkt_ready = !out_valid_reg || out_ready;
    assign take      = pkt_valid && pkt_ready;

    // Move right by X, up by Y (screen Y grows downward)
    assign sum_x = $signed({2'b00, pos_x_reg}) + $signed({{(CW-8){pkt.x_move[7]}}, pkt.x_move});
    assign sum_y = $signed({2'b00, pos_y_reg}) - $signed({{(CW-8){pkt.y_move[7]}}, pkt.y_move});

    assign pos_x_next = clamp_axis(sum_x, top_coord(screen_width));
    assign pos_y_next = clamp_axis(sum_y, top_coord(screen_height));

    assign payload = {pkt.status[BIT_YOVF], pkt.status[BIT_XOVF], pkt.status[BIT_MIDDLE],
                      pkt.status[BIT_RIGHT], pkt.status[BIT_LEFT], pos_y_next, pos_x_next};

    // Control and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= COORD_BITS'(RESET_X);
            pos_y_reg     <= COORD_BITS'(RESET_Y);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            out_valid_reg <= take || (out_valid_reg && !out_ready);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= OUT_W'(payload);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mouse_packet_cursor_tracker_unit.sv
// Mouse packet cursor tracker: top level.
//
// Input stream s_*: one mouse byte per item in s_tdata[7:0]. Bytes count in
// threes: status, X movement, Y movement (both movements signed 8-bit).
// Output stream m_*: one item per complete packet with the cursor position, X grown by
// the X movement and Y shrunk by the Y movement, each clamped to 0 .. screen size - 1
// (size 0 as 1, at most 2^COORD_BITS - 1), plus status byte button and overflow bits.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 = screen width, 1 = screen height); write only while the block is idle.
// Throughput: one byte per cycle, back to back, while s_tready is high. A result
// goes from the packet register through the cursor adder and clamp into the
// result register, which drives m_tvalid.
// Reset: cursor at (5, 2), screen 1024 x 768, next byte is a status byte.
// Stall: a held result keeps its data; the packet register still takes a
// packet behind it, and s_tready drops for any byte while both the packet
// register and the result register are full and m_tready is low.
`default_nettype none

module mouse_packet_cursor_tracker_unit
    import mpct_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int OUT_W      = ((2 * COORD_BITS + 5 + 7) / 8) * 8
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] data_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // cursor_x, cursor_y, left_pressed,
                                                 // right_pressed, middle_pressed,
                                                 // x_overflowed, y_overflowed, zero fill
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [SIZE_BITS-1:0] cfg_data
);

`include "mouse_packet_cursor_tracker_unit_defines.svh"

    logic [SIZE_BITS-1:0] screen_width_reg;
    logic [SIZE_BITS-1:0] screen_height_reg;
    logic                 pkt_valid;
    logic                 pkt_ready;
    packet_t              pkt;

    // Screen size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SIZE_BITS'(RESET_WIDTH);
            screen_height_reg <= SIZE_BITS'(RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    // Gather bytes into packets
    mpct_pkt_asm u_pkt_asm (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .data_byte  (s_tdata),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt        (pkt)
    );

    // Update and clamp the cursor, register the result
    mpct_cursor #(
        .COORD_BITS (COORD_BITS),
        .OUT_W      (OUT_W)
    ) u_cursor (
        .clk           (clk),
        .rst_n         (rst_n),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .pkt_valid     (pkt_valid),
        .pkt_ready     (pkt_ready),
        .pkt           (pkt),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata)
    );

    // Input stalls only behind a full packet register
    `MPCT_ASSERT_IMPL(a_stall_only_when_full, !s_tready, pkt_valid && !pkt_ready)
    // A packet handed to the cursor stage shows up as a result next cycle
    `MPCT_ASSERT_NEXT(a_pkt_to_result, pkt_valid && pkt_ready, m_tvalid)
    // A result appears only after a packet was handed over
    `MPCT_ASSERT_IMPL(a_result_has_source, $rose(m_tvalid), $past(pkt_valid && pkt_ready))

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the mouse packet cursor tracker: byte stream in, cursor items out.
module testbench;
    import mpct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_W       = ((2 * COORD_BITS_DEF + 5 + 7) / 8) * 8;
    localparam int COORD_TOP   = 1 << COORD_BITS_DEF;
    localparam int SIZE_MAX    = (1 << SIZE_BITS) - 1;
    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = 2000;

    // One cursor item as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [OUT_W-2*COORD_BITS_DEF-6:0] fill;
        logic                              y_ovf;
        logic                              x_ovf;
        logic                              middle;
        logic                              right;
        logic                              left;
        logic [COORD_BITS_DEF-1:0]         y;
        logic [COORD_BITS_DEF-1:0]         x;
    } cursor_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [SIZE_BITS-1:0] cfg_data;

    // Tracker state mirrored by the predictor
    byte_phase_t               trk_phase;
    logic [7:0]                trk_status;
    logic [7:0]                trk_x_move;
    logic [COORD_BITS_DEF-1:0] trk_x;
    logic [COORD_BITS_DEF-1:0] trk_y;
    logic [SIZE_BITS-1:0]      screen_w;
    logic [SIZE_BITS-1:0]      screen_h;

    cursor_t cursor_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int error_count;
    int bytes_sent;
    int cursors_seen;
    int size_writes;
    int quiet_cycles;

    mouse_packet_cursor_tracker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Clamp one axis to 0 .. size - 1, size forced into 1 .. 2^COORD_BITS
    function automatic logic [COORD_BITS_DEF-1:0] clamp_to_screen(input int p,
                                                                  input logic [SIZE_BITS-1:0] size);
        int lim;
        lim = int'(size);
        if (lim == 0)
            lim = 1;
        if (lim > COORD_TOP)
            lim = COORD_TOP;
        if (p < 0)
            return '0;
        if (p >= lim)
            return COORD_BITS_DEF'(lim - 1);
        return COORD_BITS_DEF'(p);
    endfunction

    // Advance the packet tracker by one byte, queue a cursor item on the third
    function automatic void track_byte(input logic [7:0] b);
        int      nx;
        int      ny;
        cursor_t c;
        case (trk_phase)
            PH_XMOVE:
            begin
                trk_x_move = b;
                trk_phase  = PH_YMOVE;
            end
            PH_YMOVE:
            begin
                nx = int'(trk_x) + int'($signed(trk_x_move));
                ny = int'(trk_y) - int'($signed(b));
                trk_x = clamp_to_screen(nx, screen_w);
                trk_y = clamp_to_screen(ny, screen_h);
                trk_phase = PH_STATUS;
                c        = '0;
                c.x      = trk_x;
                c.y      = trk_y;
                c.left   = trk_status[BIT_LEFT];
                c.right  = trk_status[BIT_RIGHT];
                c.middle = trk_status[BIT_MIDDLE];
                c.x_ovf  = trk_status[BIT_XOVF];
                c.y_ovf  = trk_status[BIT_YOVF];
                cursor_q.push_back(c);
            end
            default:
            begin
                trk_status = b;
                trk_phase  = PH_XMOVE;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("cursor field %s: got %0d, expected %0d", name, got, want));
    endtask

    // Check each cursor item taken from the output against the oldest prediction
    always @(posedge clk)
    begin
        cursor_t got;
        cursor_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = cursor_t'(m_tdata);
            cursors_seen++;
            if (cursor_q.size() == 0)
                report_error($sformatf("unexpected cursor item 0x%h", m_tdata));
            else
            begin
                want = cursor_q.pop_front();
                compare_field("cursor_x", got.x, want.x);
                compare_field("cursor_y", got.y, want.y);
                compare_field("left_pressed", got.left, want.left);
                compare_field("right_pressed", got.right, want.right);
                compare_field("middle_pressed", got.middle, want.middle);
                compare_field("x_overflowed", got.x_ovf, want.x_ovf);
                compare_field("y_overflowed", got.y_ovf, want.y_ovf);
                compare_field("zero fill", got.fill, 0);
            end
        end
    end

    // Drive the output ready: random stalls, or a long hold when requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Abort when no handshake or write happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one byte, with random gaps ahead of it, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        track_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] status, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(status);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Drop valid, wait for every predicted item, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (cursor_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_size(input logic idx, input logic [SIZE_BITS-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            screen_w = value;
        else
            screen_h = value;
        size_writes++;
    endtask

    function automatic logic [7:0] random_move();
        int v;
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(255));
        v = int'($urandom_range(16)) - 8;
        return v[7:0];
    endfunction

    function automatic logic [SIZE_BITS-1:0] random_size();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return SIZE_BITS'($urandom_range(SIZE_MAX));
        if (r == 1)
        begin
            case ($urandom_range(5))
                0:       return '0;
                1:       return SIZE_BITS'(1);
                2:       return SIZE_BITS'(COORD_TOP - 1);
                3:       return SIZE_BITS'(COORD_TOP);
                4:       return SIZE_BITS'(COORD_TOP + 1);
                default: return SIZE_BITS'(SIZE_MAX);
            endcase
        end
        return SIZE_BITS'($urandom_range(400, 1));
    endfunction

    // Extreme movements, every button and overflow bit, both clamps at zero
    task automatic test_directed_packets();
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'hFF, 8'h7F, 8'h80);
        send_packet(8'h01, 8'h80, 8'h7F);
        send_packet(8'h02, 8'h80, 8'h7F);
        send_packet(8'h04, 8'h7F, 8'h80);
        send_packet(8'h40, 8'h01, 8'hFF);
        send_packet(8'h80, 8'hFF, 8'h01);
    endtask

    // Upper clamp, oversized, zero and one-pixel screens, shrunken screen
    task automatic test_clamp_edges();
        write_size(CFG_SCREEN_WIDTH, SIZE_BITS'(SIZE_MAX));
        write_size(CFG_SCREEN_HEIGHT, SIZE_BITS'(SIZE_MAX));
        repeat (34) send_packet(8'h00, 8'h7F, 8'h80);
        write_size(CFG_SCREEN_WIDTH, SIZE_BITS'(100));
        write_size(CFG_SCREEN_HEIGHT, SIZE_BITS'(50));
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'h03, 8'h01, 8'hFF);
        write_size(CFG_SCREEN_WIDTH, SIZE_BITS'(1));
        write_size(CFG_SCREEN_HEIGHT, SIZE_BITS'(1));
        send_packet(8'hC0, 8'h7F, 8'h80);
        write_size(CFG_SCREEN_WIDTH, '0);
        write_size(CFG_SCREEN_HEIGHT, '0);
        send_packet(8'h07, 8'h05, 8'hFB);
        write_size(CFG_SCREEN_WIDTH, SIZE_BITS'(COORD_TOP));
        write_size(CFG_SCREEN_HEIGHT, SIZE_BITS'(COORD_TOP));
        send_packet(8'h00, 8'h7F, 8'h80);
        write_size(CFG_SCREEN_WIDTH, SIZE_BITS'(RESET_WIDTH));
        write_size(CFG_SCREEN_HEIGHT, SIZE_BITS'(RESET_HEIGHT));
    endtask

    // Hold the output off while bytes keep coming so the input stalls
    task automatic test_back_pressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_cycles   = 60;
        repeat (12) send_packet(8'($urandom_range(255)), random_move(), random_move());
        send_idle_pct = saved_pct;
    endtask

    // Mostly whole packets with random content, some stray bytes, some size changes
    task automatic test_random_traffic(input int n_items);
        int sent;
        int unsigned pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                write_size(CFG_SCREEN_WIDTH, random_size());
                write_size(CFG_SCREEN_HEIGHT, random_size());
            end
            else if (pick < 15)
            begin
                send_byte(8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                send_packet(8'($urandom_range(255)), random_move(), random_move());
                sent += 3;
            end
        end
    endtask

    // Run the tests in turn under three idling mixes
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SCREEN_WIDTH;
        cfg_data      = '0;
        hold_cycles   = 0;
        error_count   = 0;
        bytes_sent    = 0;
        cursors_seen  = 0;
        size_writes   = 0;
        quiet_cycles  = 0;
        trk_phase     = PH_STATUS;
        trk_status    = '0;
        trk_x_move    = '0;
        trk_x         = COORD_BITS_DEF'(RESET_X);
        trk_y         = COORD_BITS_DEF'(RESET_Y);
        screen_w      = SIZE_BITS'(RESET_WIDTH);
        screen_h      = SIZE_BITS'(RESET_HEIGHT);
        send_idle_pct = 17;
        recv_idle_pct = 60;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_packets();
        test_clamp_edges();
        test_random_traffic(150);
        drain();

        send_idle_pct = 60;
        recv_idle_pct = 17;
        test_back_pressure();
        test_random_traffic(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_pressure();
        test_random_traffic(150);
        drain();

        if (cursor_q.size() != 0)
            report_error($sformatf("%0d cursor items never arrived", cursor_q.size()));
        $display("covered %0d mouse bytes, %0d cursor items, %0d screen size writes",
                 bytes_sent, cursors_seen, size_writes);
        $display("directed extremes, clamp edges, back-pressure stall, three idling mixes");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mpct_pkg.sv
hw/rtl/mpct_pkt_asm.sv
hw/rtl/mpct_cursor.sv
hw/rtl/mouse_packet_cursor_tracker_unit.sv
verif/testbench.sv
